>>> hdl/artc_pkg.sv
// Shared constants, types and helper functions of the telegram receive checker.
`timescale 1ns / 1ps

package artc_pkg;

  // Frame layout.
  localparam int MAX_DATA_CHARS = 6;
  localparam int FIELD_BYTES    = 6;
  localparam int HDR_LEN        = 10;
  localparam int CHK_DIGITS     = 3;
  localparam int FRAME_LIMIT    = HDR_LEN + MAX_DATA_CHARS + CHK_DIGITS;
  localparam int IDX_W          = 5;
  localparam int DATA_W         = 8 * FIELD_BYTES;

  // Character codes.
  localparam logic [7:0] CR_CHAR    = 8'd13;
  localparam logic [7:0] DIGIT_ZERO = 8'd48;
  localparam logic [7:0] DIGIT_NINE = 8'd57;

  // Field positions inside the header.
  localparam logic [IDX_W-1:0] ACTION_POS = IDX_W'(3);
  localparam logic [IDX_W-1:0] PARAM_POS  = IDX_W'(5);
  localparam logic [IDX_W-1:0] LENGTH_POS = IDX_W'(8);

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CHECKSUM = 2'd1,
    ST_LENGTH   = 2'd2,
    ST_DIGIT    = 2'd3
  } status_t;

  // One decoded telegram.
  typedef struct packed {
    logic              frame_ok;
    status_t           status;
    logic [9:0]        address;
    logic [6:0]        action;
    logic [9:0]        parameter_res;
    logic [6:0]        data_length;
    logic [DATA_W-1:0] data_chars;
    logic [9:0]        checksum_received;
    logic [7:0]        checksum_computed;
  } result_t;

  // True when the character is an ASCII decimal digit.
  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= DIGIT_ZERO) && (ch <= DIGIT_NINE);
  endfunction

  // Shifts one decimal digit into a 10-bit accumulator; a non-digit counts as zero.
  function automatic logic [9:0] shift_digit(input logic [9:0] acc, input logic [7:0] ch);
    logic [9:0] dval;
    dval = is_digit(ch) ? {2'b00, ch - DIGIT_ZERO} : 10'd0;
    return (acc << 3) + (acc << 1) + dval;
  endfunction

endpackage

>>> hdl/artc_if.sv
// Valid/ready channel interfaces for received bytes and decoded telegrams.
`timescale 1ns / 1ps

interface artc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface artc_out_if;
  logic        valid;
  logic        ready;
  logic        frame_ok;
  logic [1:0]  status;
  logic [9:0]  address;
  logic [6:0]  action;
  logic [9:0]  parameter_res;
  logic [6:0]  data_length;
  logic [47:0] data_chars;
  logic [9:0]  checksum_received;
  logic [7:0]  checksum_computed;

  modport source (output valid, output frame_ok, output status, output address,
                  output action, output parameter_res, output data_length,
                  output data_chars, output checksum_received,
                  output checksum_computed, input ready);
  modport sink   (input valid, input frame_ok, input status, input address,
                  input action, input parameter_res, input data_length,
                  input data_chars, input checksum_received,
                  input checksum_computed, output ready);
endinterface

>>> hdl/artc_in_stage.sv
// Input register that holds one received byte until the decoder takes it.
`timescale 1ns / 1ps

module artc_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       take,
  output logic       byte_vld,
  output logic [7:0] byte_val
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;

  // The register is free when empty or when its byte is taken this cycle.
  assign in_ready = !vld_r || take;
  assign vld_nxt  = in_valid || (vld_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload loads on every input transfer.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

  assign byte_vld = vld_r;
  assign byte_val = byte_r;

endmodule

>>> hdl/artc_core.sv
// Per-byte telegram decoder: byte index, running sum and field accumulators.
`timescale 1ns / 1ps

module artc_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_vld,
  input  logic [7:0]       byte_val,
  input  logic             out_free,
  output logic             take,
  output logic             res_load,
  output artc_pkg::result_t res
);
  import artc_pkg::*;

  logic [IDX_W-1:0]  idx_r,    idx_nxt;
  logic [7:0]        sum_r,    sum_nxt;
  logic [9:0]        addr_r,   addr_nxt;
  logic [6:0]        act_r,    act_nxt;
  logic [9:0]        param_r,  param_nxt;
  logic [6:0]        len_r,    len_nxt;
  logic [DATA_W-1:0] data_r,   data_nxt;
  logic [9:0]        chk_r,    chk_nxt;
  logic              derr_r,   derr_nxt;
  logic              ovr_r,    ovr_nxt;

  logic              is_cr;
  logic [IDX_W-1:0]  dpos;
  logic [7:0]        frame_len;
  status_t           st;

  // A CR needs room in the result register; other bytes always go through.
  assign is_cr    = (byte_val == CR_CHAR);
  assign take     = byte_vld && (!is_cr || out_free);
  assign res_load = take && is_cr;
  assign dpos     = idx_r - IDX_W'(HDR_LEN);
  assign frame_len = {1'b0, len_r} + 8'(HDR_LEN + CHK_DIGITS);

  // Next state for one received byte.
  always_comb begin
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    addr_nxt  = addr_r;
    act_nxt   = act_r;
    param_nxt = param_r;
    len_nxt   = len_r;
    data_nxt  = data_r;
    chk_nxt   = chk_r;
    derr_nxt  = derr_r;
    ovr_nxt   = ovr_r;
    if (is_cr) begin
      idx_nxt   = '0;
      sum_nxt   = '0;
      addr_nxt  = '0;
      act_nxt   = '0;
      param_nxt = '0;
      len_nxt   = '0;
      data_nxt  = '0;
      chk_nxt   = '0;
      derr_nxt  = 1'b0;
      ovr_nxt   = 1'b0;
    end else if (idx_r >= IDX_W'(FRAME_LIMIT)) begin
      ovr_nxt = 1'b1;
    end else begin
      idx_nxt = idx_r + IDX_W'(1);
      if (idx_r < IDX_W'(HDR_LEN)) begin
        // Header digits are summed and decoded.
        sum_nxt = sum_r + byte_val;
        if (!is_digit(byte_val)) begin
          derr_nxt = 1'b1;
        end
        if (idx_r < ACTION_POS) begin
          addr_nxt = shift_digit(addr_r, byte_val);
        end else if (idx_r < PARAM_POS) begin
          act_nxt = 7'(shift_digit({3'b000, act_r}, byte_val));
        end else if (idx_r < LENGTH_POS) begin
          param_nxt = shift_digit(param_r, byte_val);
        end else begin
          len_nxt = 7'(shift_digit({3'b000, len_r}, byte_val));
        end
      end else if ({2'b00, dpos} < len_r) begin
        // Data characters are summed; the first ones are kept.
        sum_nxt = sum_r + byte_val;
        for (int j = 0; j < FIELD_BYTES; j++) begin
          if ((j < MAX_DATA_CHARS) && (dpos == IDX_W'(j))) begin
            data_nxt[8*(FIELD_BYTES-1-j) +: 8] = data_r[8*(FIELD_BYTES-1-j) +: 8] | byte_val;
          end
        end
      end else if ({3'b000, dpos} < ({1'b0, len_r} + 8'(CHK_DIGITS))) begin
        // Checksum digits.
        if (!is_digit(byte_val)) begin
          derr_nxt = 1'b1;
        end
        chk_nxt = shift_digit(chk_r, byte_val);
      end
    end
  end

  // Decoder state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      sum_r   <= '0;
      addr_r  <= '0;
      act_r   <= '0;
      param_r <= '0;
      len_r   <= '0;
      data_r  <= '0;
      chk_r   <= '0;
      derr_r  <= 1'b0;
      ovr_r   <= 1'b0;
    end else if (take) begin
      idx_r   <= idx_nxt;
      sum_r   <= sum_nxt;
      addr_r  <= addr_nxt;
      act_r   <= act_nxt;
      param_r <= param_nxt;
      len_r   <= len_nxt;
      data_r  <= data_nxt;
      chk_r   <= chk_nxt;
      derr_r  <= derr_nxt;
      ovr_r   <= ovr_nxt;
    end
  end

  // Status on CR: length or overrun first, then digit errors, then the checksum.
  always_comb begin
    if (ovr_r || (len_r > 7'(MAX_DATA_CHARS)) || ({3'b000, idx_r} != frame_len)) begin
      st = ST_LENGTH;
    end else if (derr_r) begin
      st = ST_DIGIT;
    end else if (chk_r != {2'b00, sum_r}) begin
      st = ST_CHECKSUM;
    end else begin
      st = ST_OK;
    end
  end

  always_comb begin
    res.frame_ok          = (st == ST_OK);
    res.status            = st;
    res.address           = addr_r;
    res.action            = act_r;
    res.parameter_res     = param_r;
    res.data_length       = len_r;
    res.data_chars        = data_r;
    res.checksum_received = chk_r;
    res.checksum_computed = sum_r;
  end

  // The index never passes the largest frame.
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_W'(FRAME_LIMIT))
    else $error("byte index beyond largest frame");

  // A CR transfer starts the next telegram from a clean state.
  a_cr_clears: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (idx_r == '0) && (sum_r == '0) && !derr_r && !ovr_r)
    else $error("state not cleared after CR");

  // A result is only produced when the result register can take it.
  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> out_free)
    else $error("result produced while result register is blocked");

  // Once overrun is seen the index stays at the limit until CR.
  a_ovr_idx: assert property (@(posedge clk) disable iff (!rst_n)
    ovr_r |-> (idx_r == IDX_W'(FRAME_LIMIT)))
    else $error("overrun flag without full frame");

endmodule

>>> hdl/artc_out_stage.sv
// Result register that holds one decoded telegram until it is transferred.
`timescale 1ns / 1ps

module artc_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_load,
  input  artc_pkg::result_t res,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_ready,
  output artc_pkg::result_t out_res
);
  import artc_pkg::*;

  logic    vld_r;
  logic    vld_nxt;
  result_t res_r;

  // Free when empty or when the held result is transferred this cycle.
  assign out_free = !vld_r || out_ready;
  assign vld_nxt  = res_load || (vld_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

>>> hdl/ascii_telegram_receive_checker_unit.sv
// Top level of the ASCII telegram receive checker.
`timescale 1ns / 1ps

// Takes one received character per cycle and checks ASCII telegrams of the form
// address(3) action(2) parameter(3) length(2) data(length) checksum(3) CR. Each
// byte goes through an input register, the decoder updates its field
// accumulators and modulo-256 sum, and on CR the decoded telegram is loaded
// into the result register when the decoder takes the CR from the input
// register, so each result passes both registers before it is shown. Throughput
// is one byte per cycle; only a CR waits, and only while the result register
// still holds an earlier telegram that has not been transferred out. Bytes
// other than CR produce no result.
module ascii_telegram_receive_checker_unit (
  input  logic              clk,
  input  logic              rst_n,
  artc_in_if.sink           in_ch,
  artc_out_if.source        out_ch
);
  import artc_pkg::*;

  logic    byte_vld;
  logic    [7:0] byte_val;
  logic    take;
  logic    res_load;
  logic    out_free;
  result_t res;
  result_t out_res;
  logic    out_vld;

  artc_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.rx_byte),
    .take     (take),
    .byte_vld (byte_vld),
    .byte_val (byte_val)
  );

  artc_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (byte_vld),
    .byte_val (byte_val),
    .out_free (out_free),
    .take     (take),
    .res_load (res_load),
    .res      (res)
  );

  artc_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_vld),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  // Result fields onto the output channel.
  assign out_ch.valid             = out_vld;
  assign out_ch.frame_ok          = out_res.frame_ok;
  assign out_ch.status            = out_res.status;
  assign out_ch.address           = out_res.address;
  assign out_ch.action            = out_res.action;
  assign out_ch.parameter_res     = out_res.parameter_res;
  assign out_ch.data_length       = out_res.data_length;
  assign out_ch.data_chars        = out_res.data_chars;
  assign out_ch.checksum_received = out_res.checksum_received;
  assign out_ch.checksum_computed = out_res.checksum_computed;

endmodule
